// ----- rtl/core/radius_match_last_index_search_core_macros.svh -----
// Assertion macros used by the top level of the radius match search core.
`ifndef RADIUS_MATCH_LAST_INDEX_SEARCH_CORE_MACROS_SVH
`define RADIUS_MATCH_LAST_INDEX_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RMLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmls: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RMLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmls: next-cycle check failed");

`endif

// ----- rtl/core/rmls_pkg.sv -----
// Shared widths and controller/datapath interface types of the radius match search core.
package rmls_pkg;

  // Fixed widths of the beat fields and of the entry count register.
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;

  // Values of the mode field.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;  // write the incoming beat into the position table
    logic start;    // latch the query point and radius, clear the running match
    logic issue;    // read one table entry and advance the scan counter
    logic publish;  // move the running match into the output register
  } rmls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the scan counter points at the last entry to read
    logic scan_empty;  // the query scans no entries at all
    logic pipe_busy;   // compare pipeline still holds entries in flight
    logic out_full;    // output register holds a beat not yet taken
    logic out_taken;   // output beat is taken at this edge
  } rmls_sts_t;

endpackage

// ----- rtl/core/rmls_ctrl.sv -----
// Controller state machine of the radius match search core.
module rmls_ctrl
  import rmls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      mode_i,
  output logic      in_stall_o,
  input  rmls_sts_t sts_i,
  output rmls_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    cmd_o.load_we = in_acc && (mode_i == MODE_LOAD);
    cmd_o.start   = in_acc && (mode_i == MODE_QUERY);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = !sts_i.scan_empty;
        if (sts_i.scan_empty || sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Publish once the last compare has landed and the output slot is free.
        if (!sts_i.pipe_busy && (!sts_i.out_full || sts_i.out_taken)) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/rmls_dpath.sv -----
// Datapath of the radius match search core: position table, distance pipeline, match tracking.
module rmls_dpath
  import rmls_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rmls_cmd_t             cmd_i,
  output rmls_sts_t             sts_o,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  input  logic [COORD_BITS-2:0] search_radius_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  found_o,
  output logic [IDX_W-1:0]      match_index_o
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SQW  = 2 * COORD_BITS;
  localparam int unsigned SUMW = SQW + 2;
  localparam int unsigned EW   = 3 * COORD_BITS;

  logic [EW-1:0] mem_q [TABLE_DEPTH];

  logic [CNT_W-1:0]      entry_count_q;
  logic [CW-1:0]         scan_cnt_q, scan_len_q;
  logic [CW-1:0]         scan_nxt;
  logic [31:0]           cnt_ext, len_sat, wr_idx_ext, best_ext;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic                  wr_in_range;

  logic [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [SQW-1:0]        limit_q;

  logic [EW-1:0]         rd_q;
  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic [AW-1:0]         s1_idx_q, s2_idx_q, s3_idx_q;
  logic [COORD_BITS-1:0] ex, ey, ez;
  logic [COORD_BITS-1:0] dx_q, dy_q, dz_q;
  logic [SQW-1:0]        sqx_q, sqy_q, sqz_q;
  logic [SUMW-1:0]       dist_sum;
  logic                  in_reach;

  logic                  hit_q;
  logic [AW-1:0]         best_q;
  logic                  out_vld_q, found_q;
  logic [IDX_W-1:0]      match_q;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Table write and registered read.
  assign wr_idx_ext  = 32'(entry_index_i);
  assign wr_addr     = wr_idx_ext[AW-1:0];
  assign wr_in_range = (wr_idx_ext < TABLE_DEPTH);
  assign rd_addr     = scan_cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && wr_in_range) begin
      mem_q[wr_addr] <= {coord_x_i, coord_y_i, coord_z_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
  end

  // Scan length saturates at the table depth.
  assign cnt_ext  = 32'(entry_count_q);
  assign len_sat  = (cnt_ext > TABLE_DEPTH) ? TABLE_DEPTH : cnt_ext;
  assign scan_nxt = scan_cnt_q + CW'(1);

  assign ex = rd_q[EW-1 -: COORD_BITS];
  assign ey = rd_q[SQW-1 -: COORD_BITS];
  assign ez = rd_q[COORD_BITS-1:0];

  assign dist_sum = SUMW'(sqx_q) + SUMW'(sqy_q) + SUMW'(sqz_q);
  assign in_reach = dist_sum < SUMW'(limit_q);

  // Query operands and pipeline payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q       <= coord_x_i;
      py_q       <= coord_y_i;
      pz_q       <= coord_z_i;
      limit_q    <= (SQW'(search_radius_i) * SQW'(search_radius_i)) << 2;
      scan_len_q <= len_sat[CW-1:0];
    end
    s1_idx_q <= rd_addr;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    dx_q     <= abs_diff(px_q, ex);
    dy_q     <= abs_diff(py_q, ey);
    dz_q     <= abs_diff(pz_q, ez);
    sqx_q    <= SQW'(dx_q) * SQW'(dx_q);
    sqy_q    <= SQW'(dy_q) * SQW'(dy_q);
    sqz_q    <= SQW'(dz_q) * SQW'(dz_q);
  end

  assign best_ext = 32'(best_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_q <= '0;
    end else if (s3_vld_q && in_reach) begin
      best_q <= s3_idx_q;
    end
    if (cmd_i.publish) begin
      found_q <= hit_q;
      match_q <= best_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      scan_cnt_q    <= '0;
      s1_vld_q      <= 1'b0;
      s2_vld_q      <= 1'b0;
      s3_vld_q      <= 1'b0;
      hit_q         <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.issue) begin
        scan_cnt_q <= scan_nxt;
      end
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (cmd_i.start) begin
        hit_q <= 1'b0;
      end else if (s3_vld_q && in_reach) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.publish) begin
        out_vld_q <= 1'b1;
      end else if (sts_o.out_taken) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_last  = (scan_nxt == scan_len_q);
  assign sts_o.scan_empty = (scan_len_q == '0);
  assign sts_o.pipe_busy  = s1_vld_q || s2_vld_q || s3_vld_q;
  assign sts_o.out_full   = out_vld_q;
  assign sts_o.out_taken  = out_vld_q && !out_stall_i;

  assign out_valid_o   = out_vld_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;

endmodule

// ----- rtl/core/radius_match_last_index_search_core.sv -----
// Top level of the radius match search core: last table entry within twice a radius.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   input   | in        | in_valid_i / in_stall_o | mode, entry_index, coord_x/y/z, radius
//   output  | out       | out_valid_o / out_stall_i | found, match_index
//   config  | in        | cfg_we_i                | cfg_wdata_i (entry_count)
//
// A load beat writes one table entry; the input is ready again at once.
// A query beat scans n = min(entry_count, TABLE_DEPTH) entries through the single table read
// port; out_valid_o rises when the result is published after the compare pipeline drains.
// The input stalls from a query's acceptance until its result is in the output register.
// A result waiting on out_stall_i does not block loads; a following query waits only at publish.
// Reset clears the entry count and all control state; the table itself holds no reset value.
//
// A query latches its point and the limit 4*r*r, then streams table entries through a
// read / difference / square / sum-and-compare pipeline. Every entry whose squared distance
// falls strictly below the limit overwrites the running match, so the last hit in scan
// order is the highest matching index. An empty scan or no hit reports found = 0, index 0.
module radius_match_last_index_search_core
  import rmls_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  input  logic [COORD_BITS-2:0] search_radius_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      match_index_o
);

`include "radius_match_last_index_search_core_macros.svh"

  rmls_cmd_t cmd;
  rmls_sts_t sts;

  // The controller sequences load, scan and drain; it never touches payload.
  rmls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the table, the compare pipeline and the output register.
  rmls_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .search_radius_i (search_radius_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .found_o         (found_o),
    .match_index_o   (match_index_o)
  );

  // An accepted query closes the input until its result is published.
  `RMLS_ASSERT_NEXT(a_query_closes_input, cmd.start, in_stall_o)
  // A result is never published while entries are still in the compare pipeline.
  `RMLS_ASSERT_SAME(a_publish_after_drain, cmd.publish, !sts.pipe_busy)
  // Table reads only happen while a query owns the block.
  `RMLS_ASSERT_SAME(a_issue_only_in_query, cmd.issue, in_stall_o && !cmd.publish)
  // A publish always presents a result beat in the next cycle.
  `RMLS_ASSERT_NEXT(a_publish_shows_beat, cmd.publish, out_valid_o)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the radius match search core: loads, queries and count settings.
module tb_top;
  import rmls_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned COORD_BITS     = 24;
  localparam int unsigned RADIUS_BITS    = COORD_BITS - 1;
  localparam logic [COORD_BITS-1:0]  COORD_MAX  = '1;
  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
  // Settle time that covers any table write still in flight.
  localparam int unsigned SETTLE_CYCLES  = 16;
  // Slowest correct gap is a full-table query plus a receiver stall.
  localparam int unsigned WATCHDOG_LIMIT = 10000;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [RADIUS_BITS-1:0] radius_t;
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } match_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic             mode        = MODE_LOAD;
  logic [IDX_W-1:0] entry_index = '0;
  coord_t           coord_x     = '0;
  coord_t           coord_y     = '0;
  coord_t           coord_z     = '0;
  radius_t          search_radius = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             found;
  logic [IDX_W-1:0] match_index;

  // Shadow copy of the position table and of the entry count register.
  coord_t      slot_x [TABLE_DEPTH];
  coord_t      slot_y [TABLE_DEPTH];
  coord_t      slot_z [TABLE_DEPTH];
  bit          slot_loaded [TABLE_DEPTH];
  int unsigned entry_count_model = 0;

  // Predicted query results, oldest first.
  match_t      expected_matches [$];

  int unsigned send_idle_pct  = 14;
  int unsigned recv_stall_pct = 61;
  int unsigned beats_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  always #5 clk = ~clk;

  radius_match_last_index_search_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .entry_index_i   (entry_index),
    .coord_x_i       (coord_x),
    .coord_y_i       (coord_y),
    .coord_z_i       (coord_z),
    .search_radius_i (search_radius),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .found_o         (found),
    .match_index_o   (match_index)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned sq_gap(input coord_t a, input coord_t b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned d;
    ua = a;
    ub = b;
    d  = (ua >= ub) ? (ua - ub) : (ub - ua);
    return d * d;
  endfunction

  // The scan keeps overwriting the match on every hit, so the last hit in scan order
  // is the highest matching slot. The compare is strict: a distance of exactly twice
  // the radius misses, and a zero radius never hits.
  function automatic match_t last_match_in_radius(input coord_t px, input coord_t py,
                                                  input coord_t pz, input radius_t r);
    longint unsigned rr;
    longint unsigned limit;
    int unsigned     scan_len;
    match_t          m;
    rr       = r;
    limit    = 4 * rr * rr;
    scan_len = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_model;
    m        = '0;
    for (int unsigned k = 0; k < scan_len; k++) begin
      if (sq_gap(px, slot_x[k]) + sq_gap(py, slot_y[k]) + sq_gap(pz, slot_z[k]) < limit) begin
        m.found = 1'b1;
        m.index = k[IDX_W-1:0];
      end
    end
    return m;
  endfunction

  // Moves a coordinate by a random amount of up to 2**s either way, clamped to the range.
  function automatic coord_t jitter(input coord_t base, input int unsigned s);
    longint span;
    longint v;
    span = longint'(1) << s;
    v    = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Each result beat taken at this edge is compared with the oldest prediction.
  // The receiver's stall for the next cycle is drawn afterwards.
  always @(posedge clk) begin : result_check
    match_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("result beat with no query pending", 0, match_index);
      end else begin
        want = expected_matches.pop_front();
        if (found !== want.found)
          report_mismatch("found", want.found, found);
        if (match_index !== want.index)
          report_mismatch("match_index", want.index, match_index);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("radius_match_last_index_search_core verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one beat, with a random idle stretch first. Once the beat is accepted the
  // shadow table is updated for a load, or the result of a query is predicted.
  task automatic send_beat(input logic m, input logic [IDX_W-1:0] idx, input coord_t x,
                           input coord_t y, input coord_t z, input radius_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    entry_index   <= idx;
    coord_x       <= x;
    coord_y       <= y;
    coord_z       <= z;
    search_radius <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (m == MODE_LOAD) begin
      if (idx < TABLE_DEPTH) begin
        slot_x[idx]      = x;
        slot_y[idx]      = y;
        slot_z[idx]      = z;
        slot_loaded[idx] = 1'b1;
      end
    end else begin
      expected_matches.push_back(last_match_in_radius(x, y, z, r));
    end
    beats_sent++;
  endtask

  // The count register may only change while the core is idle. The sender holds off
  // until every pending result has arrived, then waits out any load still in flight.
  task automatic set_entry_count(input int unsigned value);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    entry_count_model = value;
  endtask

  // Loads a slot either with a random position or close to another loaded slot, so
  // that queries often see several hits and the last one has to win.
  task automatic send_random_load(input int unsigned slot);
    int unsigned src;
    int unsigned s;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    src = $urandom_range(0, TABLE_DEPTH - 1);
    s   = $urandom_range(0, 16);
    if (slot_loaded[src] && $urandom_range(0, 99) < 40) begin
      x = jitter(slot_x[src], s);
      y = jitter(slot_y[src], s);
      z = jitter(slot_z[src], s);
    end else begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      z = coord_t'($urandom);
    end
    send_beat(MODE_LOAD, slot[IDX_W-1:0], x, y, z, radius_t'($urandom));
  endtask

  // Most queries land near a scanned slot with a radius on the scale of the offset,
  // so hits and misses both come up; the rest are fully random.
  task automatic send_random_query();
    int unsigned scan_len;
    int unsigned k;
    int unsigned s;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    radius_t     r;
    scan_len = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_model;
    s        = $urandom_range(0, RADIUS_BITS - 1);
    if (scan_len != 0 && $urandom_range(0, 99) < 70) begin
      k = $urandom_range(0, scan_len - 1);
      x = jitter(slot_x[k], s);
      y = jitter(slot_y[k], s);
      z = jitter(slot_z[k], s);
      if ($urandom_range(0, 3) == 0 || s + 1 >= RADIUS_BITS)
        r = radius_t'($urandom);
      else
        r = radius_t'($urandom_range(0, 1 << (s + 1)));
    end else begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      z = coord_t'($urandom);
      r = radius_t'($urandom);
    end
    send_beat(MODE_QUERY, IDX_W'($urandom), x, y, z, r);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the corner cases of the search, on a four-entry table.
  task automatic test_directed_corners();
    coord_t ax;
    coord_t ay;
    coord_t az;
    ax = 24'h5A5A5A;
    ay = 24'h123456;
    az = 24'hA5A5A5;
    // The count is zero after reset, so this scan is empty.
    send_beat(MODE_QUERY, '1, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
    // Loads carry a radius that must be ignored.
    send_beat(MODE_LOAD, 0, 0, 0, 0, RADIUS_MAX);
    send_beat(MODE_LOAD, 1, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_beat(MODE_LOAD, 2, ax, ay, az, 0);
    send_beat(MODE_LOAD, 3, ax, ay, az, 5);
    send_beat(MODE_LOAD, '1, COORD_MAX, 0, COORD_MAX, 0);
    set_entry_count(4);
    // Two identical entries hit; the later slot is reported.
    send_beat(MODE_QUERY, 0, ax, ay, az, 1);
    // Nothing is strictly below a zero limit, not even an exact match.
    send_beat(MODE_QUERY, '1, ax, ay, az, 0);
    send_beat(MODE_QUERY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    // A distance of exactly twice the radius misses, one less hits.
    send_beat(MODE_QUERY, 5, 2000, 0, 0, 1000);
    send_beat(MODE_QUERY, 5, 1999, 0, 0, 1000);
    send_beat(MODE_QUERY, 0, 0, 0, 0, RADIUS_MAX);
    send_beat(MODE_QUERY, 0, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
    // With only slot 0 scanned, the copies of the point in slots 2 and 3 are out of view.
    set_entry_count(1);
    send_beat(MODE_QUERY, 0, ax, ay, az, 1);
    send_beat(MODE_QUERY, 0, 0, 0, 0, 1);
  endtask

  // Random loads and queries in segments, each with its own entry count. Slots up to
  // the count are always loaded before a query can scan them.
  task automatic test_random_traffic(input int unsigned beats);
    int unsigned start;
    int unsigned count;
    int unsigned slot_hi;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160) : $urandom_range(0, 48);
      set_entry_count(count);
      for (int unsigned k = 0; k < count; k++)
        if (!slot_loaded[k]) send_random_load(k);
      slot_hi = (count + 8 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : count + 8;
      repeat ($urandom_range(8, 30)) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 3) == 0)
            send_random_load($urandom_range(0, TABLE_DEPTH - 1));
          else
            send_random_load($urandom_range(0, slot_hi));
        end else begin
          send_random_query();
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 14;
    recv_stall_pct = 61;
    test_directed_corners();
    test_random_traffic(175);

    send_idle_pct  = 61;
    recv_stall_pct = 14;
    test_random_traffic(175);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(175);

    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radius_match_last_index_search_core verification clean");
    end else begin
      $display("radius_match_last_index_search_core verification failed");
    end
    $finish;
  end

endmodule
